// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, widths and character constants for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int CHAR_W         = 21;
    localparam int KIND_W         = 2;
    localparam int TOTAL_W        = 16;
    localparam int COUNT_BITS_DEF = 16;

    // stream widths; the data widths are padded to whole bytes
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_TUSER_W  = 3;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // token kinds
    localparam logic [KIND_W-1:0] KIND_IDENT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRING = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd3;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 21'd0;
    localparam logic [CHAR_W-1:0] CH_LF     = 21'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 21'd32;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 21'd34;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 21'd36;
    localparam logic [CHAR_W-1:0] CH_STAR   = 21'd42;
    localparam logic [CHAR_W-1:0] CH_DOT    = 21'd46;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 21'd47;
    localparam logic [CHAR_W-1:0] CH_0      = 21'd48;
    localparam logic [CHAR_W-1:0] CH_9      = 21'd57;
    localparam logic [CHAR_W-1:0] CH_UA     = 21'd65;
    localparam logic [CHAR_W-1:0] CH_UZ     = 21'd90;
    localparam logic [CHAR_W-1:0] CH_USCORE = 21'd95;
    localparam logic [CHAR_W-1:0] CH_LA     = 21'd97;
    localparam logic [CHAR_W-1:0] CH_LZ     = 21'd122;

    // one result item
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [KIND_W-1:0]  kind;
        logic               first;
        logic               last;
        logic               eot;
        logic [TOTAL_W-1:0] total;
        logic               last_run;
    } t_res;

    // results of one input item: one or two
    typedef struct packed {
        logic two;
        t_res item0;
        t_res item1;
    } t_pair;

    function automatic logic f_is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || (c == CH_USCORE);
    endfunction

    function automatic logic f_is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic t_res f_item(input logic [CHAR_W-1:0] ch, input logic [KIND_W-1:0] kind,
                                    input logic first, input logic last);
        t_res r;
        r.ch       = ch;
        r.kind     = kind;
        r.first    = first;
        r.last     = last;
        r.eot      = 1'b0;
        r.total    = '0;
        r.last_run = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/source_text_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming tokenizer: characters in, tagged token characters out.
// ----------------------------------------------------------------------------
// Usage
//   Slave channel: one character code per item in i_s_tdata; code zero ends
//   the text. Master channel: token characters with kind, first and last
//   marks; the end-of-text item carries the token count and sets tuser bit 2.
//   o_m_tlast marks the final item caused by one input character.
//   Throughput: one character per cycle while the queue has room. A
//   character that causes two items (a token closed together with a new
//   symbol, quote or end of text) needs two output transfers, so output
//   bandwidth sets the sustained rate. The scanner pushes into the queue at
//   the accepting edge; the queue loads the output register once that
//   register is empty or its item is being taken.
//   A four-entry queue decouples the scanner from the output stage; the
//   scanner takes input whenever the queue has room, also while the receiver
//   stalls, until the queue fills.
//   Identifier and number characters are held back by one character, until
//   the next one shows whether the token closes.
//   Reset clears scan mode, token count, queue and output register.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top #(
    parameter int COUNT_BITS = stt_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [stt_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // [20:0] char_code
    // master side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [stt_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // [20:0] out_char, [21] first_of_token,
                                                        // [22] last_of_token, [38:23] token_total
    output logic [stt_pkg::OUT_TUSER_W-1:0] o_m_tuser,  // [1:0] token_kind, [2] end_of_text
    output logic                            o_m_tlast   // last_of_run
);
    import stt_pkg::*;

    logic  take;
    logic  push;
    t_pair push_pair;
    logic  q_full;
    logic  q_empty;
    logic  pop;
    t_pair head;
    t_res  out_item;

    assign o_s_tready = !q_full;
    assign take       = i_s_tvalid && o_s_tready;

    stt_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (i_s_tdata[CHAR_W-1:0]),
        .o_push  (push),
        .o_pair  (push_pair)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty)
    );

    stt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_item  (out_item)
    );

    // pack the output item
    assign o_m_tdata = {1'b0, out_item.total, out_item.last, out_item.first, out_item.ch};
    assign o_m_tuser = {out_item.eot, out_item.kind};
    assign o_m_tlast = out_item.last_run;

    // end of text is always the final item of its character
    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && out_item.eot) |-> o_m_tlast)
        else $error("end-of-text item without tlast");

    // a symbol token is exactly one character long
    a_symbol_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !out_item.eot && out_item.kind == KIND_SYMBOL) |->
        (out_item.first && out_item.last))
        else $error("symbol token not a single character");

    // queue cannot be full and empty together
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("queue full and empty at once");

endmodule

// ===== rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Scanner: classifies each character against the scan mode and builds the
// one or two result items it causes, ready to push into the queue.
// ----------------------------------------------------------------------------
module stt_front #(
    parameter int COUNT_BITS = stt_pkg::COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [stt_pkg::CHAR_W-1:0] i_char,
    output logic                       o_push,
    output stt_pkg::t_pair             o_pair
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_SLASH, M_LINE, M_BLOCK, M_BSTAR
    } t_mode;

    localparam int LOW_W = (COUNT_BITS < TOTAL_W) ? COUNT_BITS : TOTAL_W;

    t_mode                   r_mode, n_mode;
    logic [CHAR_W-1:0]       r_held, n_held;
    logic [KIND_W-1:0]       r_kind, n_kind;
    logic                    r_first, n_first;
    logic                    r_dot, n_dot;
    logic [COUNT_BITS-1:0]   r_count, n_count;

    logic [1:0]              nres;
    t_res                    items [2];
    logic                    do_idle;
    logic [COUNT_BITS-1:0]   cnt;

    function automatic logic [COUNT_BITS-1:0] f_sat(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // next-state and result building for one character
    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_kind  = r_kind;
        n_first = r_first;
        n_dot   = r_dot;
        cnt     = r_count;
        nres    = 2'd0;
        items[0] = '0;
        items[1] = '0;
        do_idle = 1'b0;

        unique case (r_mode)
            M_IDENT: begin
                if (f_is_alpha(i_char) || i_char == CH_DOLLAR) begin
                    items[nres[0]] = f_item(r_held, r_kind, r_first, 1'b0);
                    nres = nres + 2'd1;
                    n_held  = i_char;
                    n_first = 1'b0;
                end else begin
                    items[nres[0]] = f_item(r_held, r_kind, r_first, 1'b1);
                    nres = nres + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_NUMBER: begin
                if (f_is_digit(i_char) || i_char == CH_DOT) begin
                    // repeated dots are dropped
                    if (!(i_char == CH_DOT && r_dot)) begin
                        items[nres[0]] = f_item(r_held, r_kind, r_first, 1'b0);
                        nres = nres + 2'd1;
                        n_held  = i_char;
                        n_first = 1'b0;
                        if (i_char == CH_DOT) n_dot = 1'b1;
                    end
                end else begin
                    items[nres[0]] = f_item(r_held, r_kind, r_first, 1'b1);
                    nres = nres + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_STRING: begin
                if (i_char == CH_QUOTE) begin
                    items[nres[0]] = f_item(i_char, KIND_STRING, 1'b0, 1'b1);
                    nres = nres + 2'd1;
                    n_mode = M_IDLE;
                end else if (i_char == CH_NUL) begin
                    // unterminated string: supply the closing quote
                    items[nres[0]] = f_item(CH_QUOTE, KIND_STRING, 1'b0, 1'b1);
                    nres = nres + 2'd1;
                    do_idle = 1'b1;
                end else begin
                    items[nres[0]] = f_item(i_char, KIND_STRING, 1'b0, 1'b0);
                    nres = nres + 2'd1;
                end
            end
            M_SLASH: begin
                if (i_char == CH_SLASH) begin
                    n_mode = M_LINE;
                end else if (i_char == CH_STAR) begin
                    n_mode = M_BLOCK;
                end else begin
                    // lone slash is a symbol token
                    items[nres[0]] = f_item(CH_SLASH, KIND_SYMBOL, 1'b1, 1'b1);
                    nres = nres + 2'd1;
                    cnt = f_sat(cnt);
                    do_idle = 1'b1;
                end
            end
            M_LINE: begin
                if (i_char == CH_LF) n_mode = M_IDLE;
                else if (i_char == CH_NUL) do_idle = 1'b1;
            end
            M_BLOCK: begin
                if (i_char == CH_STAR) n_mode = M_BSTAR;
                else if (i_char == CH_NUL) do_idle = 1'b1;
            end
            M_BSTAR: begin
                if (i_char == CH_SLASH) n_mode = M_IDLE;
                else if (i_char == CH_NUL) do_idle = 1'b1;
                else if (i_char != CH_STAR) n_mode = M_BLOCK;
            end
            M_IDLE: begin
                do_idle = 1'b1;
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // character taken between tokens
        if (do_idle) begin
            n_mode = M_IDLE;
            priority if (i_char == CH_NUL) begin
                items[nres[0]] = f_item(CH_NUL, KIND_IDENT, 1'b0, 1'b0);
                items[nres[0]].eot   = 1'b1;
                items[nres[0]].total = TOTAL_W'(cnt[LOW_W-1:0]);
                nres = nres + 2'd1;
                cnt = '0;
            end else if (f_is_alpha(i_char)) begin
                n_held  = i_char;
                n_first = 1'b1;
                n_kind  = KIND_IDENT;
                n_mode  = M_IDENT;
                cnt = f_sat(cnt);
            end else if (f_is_digit(i_char)) begin
                n_held  = i_char;
                n_first = 1'b1;
                n_kind  = KIND_NUMBER;
                n_dot   = 1'b0;
                n_mode  = M_NUMBER;
                cnt = f_sat(cnt);
            end else if (i_char == CH_QUOTE) begin
                items[nres[0]] = f_item(i_char, KIND_STRING, 1'b1, 1'b0);
                nres = nres + 2'd1;
                n_mode = M_STRING;
                cnt = f_sat(cnt);
            end else if (i_char <= CH_SPACE) begin
                // blank, skipped
            end else if (i_char == CH_SLASH) begin
                n_mode = M_SLASH;
            end else begin
                items[nres[0]] = f_item(i_char, KIND_SYMBOL, 1'b1, 1'b1);
                nres = nres + 2'd1;
                cnt = f_sat(cnt);
            end
        end

        n_count = cnt;

        // mark the final result of this character
        if (nres == 2'd2) items[1].last_run = 1'b1;
        else              items[0].last_run = 1'b1;
    end

    assign o_push       = i_take && (nres != 2'd0);
    assign o_pair.two   = (nres == 2'd2);
    assign o_pair.item0 = items[0];
    assign o_pair.item1 = items[1];

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_held  <= '0;
            r_kind  <= KIND_IDENT;
            r_first <= 1'b0;
            r_dot   <= 1'b0;
            r_count <= '0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_kind  <= n_kind;
            r_first <= n_first;
            r_dot   <= n_dot;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue
// Small register queue of result pairs between scanner and output stage.
// ----------------------------------------------------------------------------
module stt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stt_pkg::t_pair i_pair,
    output logic           o_full,
    input  logic           i_pop,
    output stt_pkg::t_pair o_head,
    output logic           o_empty
);
    import stt_pkg::*;

    t_pair              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_pair;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Output stage: splits each queued pair into single items and holds the
// current item in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module stt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stt_pkg::t_pair i_head,
    input  logic           i_empty,
    output logic           o_pop,
    input  logic           i_ready,
    output logic           o_valid,
    output stt_pkg::t_res  o_item
);
    import stt_pkg::*;

    logic r_valid;
    logic r_idx;
    t_res r_item;
    logic load;

    assign load    = (!r_valid || i_ready) && !i_empty;
    assign o_pop   = load && (!i_head.two || r_idx);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // output register and pair position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= !o_pop;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_item <= r_idx ? i_head.item1 : i_head.item0;
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the source text tokenizer. A short directed walk
// covers every token class, comments, the lone slash, the unterminated string
// and the code extremes. Random text built from well-formed tokens with random
// content follows, with some noise mixed in. A short text at the end checks
// that the token count restarts. Every item accepted on the slave side is fed
// to a local scanner model. Each item on the master side is checked in order
// against what that model queued up.
// ----------------------------------------------------------------------------
module tb_top;

    import stt_pkg::*;

    localparam int  COUNT_BITS  = COUNT_BITS_DEF;
    localparam int  CLK_HALF    = 5;
    localparam int  LIMIT_CYC   = 1_000_000;
    localparam int  MAX_REPORTS = 10;

    // extra character codes used by the stimulus
    localparam logic [CHAR_W-1:0] CH_SOH    = 21'd1;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 21'd40;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 21'd43;
    localparam logic [CHAR_W-1:0] CH_TILDE  = 21'd126;
    localparam logic [CHAR_W-1:0] CH_DEL    = 21'd127;
    localparam logic [CHAR_W-1:0] CH_TOP    = 21'h10FFFF;

    // scanner states of the local model
    typedef enum logic [2:0] {
        SC_IDLE, SC_IDENT, SC_NUMBER, SC_STRING, SC_SLASH, SC_LINE, SC_BLOCK, SC_BSTAR
    } t_scan_state;

    // one directed row: code sent, and a hand-written result where obvious
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              typed;
        t_res              res;
    } t_dir_row;

    localparam int N_DIR = 28;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{CH_PLUS,    1'b1, '{CH_PLUS, KIND_SYMBOL, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1}},
        '{CH_TOP,     1'b1, '{CH_TOP,  KIND_SYMBOL, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1}},
        '{CH_SPACE,   1'b0, '0},
        '{CH_SOH,     1'b0, '0},
        '{CH_LA,      1'b0, '0},
        '{CH_DOLLAR,  1'b0, '0},
        '{CH_UZ,      1'b0, '0},
        '{CH_LPAREN,  1'b0, '0},
        '{CH_9,       1'b0, '0},
        '{CH_DOT,     1'b0, '0},
        '{CH_DOT,     1'b0, '0},
        '{CH_0,       1'b0, '0},
        '{CH_QUOTE,   1'b0, '0},
        '{CH_LZ,      1'b0, '0},
        '{CH_QUOTE,   1'b0, '0},
        '{CH_SLASH,   1'b0, '0},
        '{CH_USCORE,  1'b0, '0},
        '{CH_SLASH,   1'b0, '0},
        '{CH_SLASH,   1'b0, '0},
        '{CH_LF,      1'b0, '0},
        '{CH_SLASH,   1'b0, '0},
        '{CH_STAR,    1'b0, '0},
        '{CH_SLASH,   1'b0, '0},
        '{CH_STAR,    1'b0, '0},
        '{CH_SLASH,   1'b0, '0},
        '{CH_QUOTE,   1'b0, '0},
        '{CH_NUL,     1'b0, '0},
        '{CH_NUL,     1'b1, '{CH_NUL,  KIND_IDENT,  1'b0, 1'b0, 1'b1, 16'd0, 1'b1}}
    };

    // ports
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // [20:0] ch, [21] first, [22] last, [38:23] total
    logic [OUT_TUSER_W-1:0] o_m_tuser;   // [1:0] kind, [2] end of text
    logic                   o_m_tlast;   // last item of one input

    // local scanner model state
    t_scan_state       scan_state;
    logic [CHAR_W-1:0] held_ch;
    logic [KIND_W-1:0] held_kind;
    logic              held_first;
    logic              dot_seen;
    longint unsigned   tokens_seen;

    t_res              token_items_due[$];
    logic [CHAR_W-1:0] char_plan[$];

    bit  sender_idles   = 1'b0;
    bit  receiver_idles = 1'b0;
    int  stall_left     = 0;
    int  fail_count     = 0;
    int  chars_sent     = 0;
    int  items_checked  = 0;
    int  texts_closed   = 0;

    source_text_tokenizer_top #(
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Local scanner model
    // ------------------------------------------------------------------------
    function automatic bit opens_ident(input logic [CHAR_W-1:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_USCORE;
    endfunction

    function automatic bit is_numeral(input logic [CHAR_W-1:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic t_res char_item(input logic [CHAR_W-1:0] ch, input logic [KIND_W-1:0] kind,
                                       input logic first, input logic last);
        t_res r;
        r          = '0;
        r.ch       = ch;
        r.kind     = kind;
        r.first    = first;
        r.last     = last;
        return r;
    endfunction

    task automatic count_token();
        if (tokens_seen < (64'd1 << COUNT_BITS) - 1) tokens_seen++;
    endtask

    task automatic release_held(input logic last);
        token_items_due.push_back(char_item(held_ch, held_kind, held_first, last));
    endtask

    // character seen between tokens
    task automatic start_token(input logic [CHAR_W-1:0] c);
        t_res eot;
        scan_state = SC_IDLE;
        if (c == CH_NUL) begin
            eot       = '0;
            eot.eot   = 1'b1;
            eot.total = tokens_seen[TOTAL_W-1:0];
            token_items_due.push_back(eot);
            tokens_seen = '0;
            texts_closed++;
        end else if (opens_ident(c)) begin
            held_ch    = c;
            held_kind  = KIND_IDENT;
            held_first = 1'b1;
            scan_state = SC_IDENT;
            count_token();
        end else if (is_numeral(c)) begin
            held_ch    = c;
            held_kind  = KIND_NUMBER;
            held_first = 1'b1;
            dot_seen   = 1'b0;
            scan_state = SC_NUMBER;
            count_token();
        end else if (c == CH_QUOTE) begin
            token_items_due.push_back(char_item(c, KIND_STRING, 1'b1, 1'b0));
            scan_state = SC_STRING;
            count_token();
        end else if (c <= CH_SPACE) begin
            // blank
        end else if (c == CH_SLASH) begin
            scan_state = SC_SLASH;
        end else begin
            token_items_due.push_back(char_item(c, KIND_SYMBOL, 1'b1, 1'b1));
            count_token();
        end
    endtask

    // one accepted character: queue the items it causes
    task automatic scan_char(input logic [CHAR_W-1:0] c);
        int n0;
        n0 = token_items_due.size();
        case (scan_state)
            SC_IDENT: begin
                if (opens_ident(c) || c == CH_DOLLAR) begin
                    release_held(1'b0);
                    held_ch    = c;
                    held_first = 1'b0;
                end else begin
                    release_held(1'b1);
                    start_token(c);
                end
            end
            SC_NUMBER: begin
                if (is_numeral(c) || c == CH_DOT) begin
                    // later dots are dropped
                    if (!(c == CH_DOT && dot_seen)) begin
                        release_held(1'b0);
                        held_ch    = c;
                        held_first = 1'b0;
                        if (c == CH_DOT) dot_seen = 1'b1;
                    end
                end else begin
                    release_held(1'b1);
                    start_token(c);
                end
            end
            SC_STRING: begin
                if (c == CH_QUOTE) begin
                    token_items_due.push_back(char_item(c, KIND_STRING, 1'b0, 1'b1));
                    scan_state = SC_IDLE;
                end else if (c == CH_NUL) begin
                    // closing quote supplied at end of text
                    token_items_due.push_back(char_item(CH_QUOTE, KIND_STRING, 1'b0, 1'b1));
                    start_token(c);
                end else begin
                    token_items_due.push_back(char_item(c, KIND_STRING, 1'b0, 1'b0));
                end
            end
            SC_SLASH: begin
                if (c == CH_SLASH) begin
                    scan_state = SC_LINE;
                end else if (c == CH_STAR) begin
                    scan_state = SC_BLOCK;
                end else begin
                    token_items_due.push_back(char_item(CH_SLASH, KIND_SYMBOL, 1'b1, 1'b1));
                    count_token();
                    start_token(c);
                end
            end
            SC_LINE: begin
                if (c == CH_LF) scan_state = SC_IDLE;
                else if (c == CH_NUL) start_token(c);
            end
            SC_BLOCK: begin
                if (c == CH_STAR) scan_state = SC_BSTAR;
                else if (c == CH_NUL) start_token(c);
            end
            SC_BSTAR: begin
                if (c == CH_SLASH) scan_state = SC_IDLE;
                else if (c == CH_NUL) start_token(c);
                else if (c != CH_STAR) scan_state = SC_BLOCK;
            end
            default: start_token(c);
        endcase
        if (token_items_due.size() > n0) token_items_due[$].last_run = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return CH_LA + CHAR_W'(r);
        if (r < 52) return CH_UA + CHAR_W'(r - 26);
        return CH_USCORE;
    endfunction

    // printable symbol or a high code point
    function automatic logic [CHAR_W-1:0] rand_symbol();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 1)) return CHAR_W'($urandom_range(CH_DEL, CH_TOP));
        c = CHAR_W'($urandom_range(CH_SPACE + 1, CH_TILDE));
        while (opens_ident(c) || is_numeral(c) || c == CH_QUOTE || c == CH_SLASH)
            c = CHAR_W'($urandom_range(CH_SPACE + 1, CH_TILDE));
        return c;
    endfunction

    // random text from well-formed tokens, with some broken ones and noise
    task automatic plan_text(input int n);
        int pick, len;
        logic [CHAR_W-1:0] c;
        while (char_plan.size() < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                char_plan.push_back(rand_letter());
                len = $urandom_range(0, 5);
                repeat (len) char_plan.push_back($urandom_range(0, 7) == 0 ? CH_DOLLAR
                                                                            : rand_letter());
            end else if (pick < 38) begin
                char_plan.push_back(CHAR_W'($urandom_range(CH_0, CH_9)));
                len = $urandom_range(0, 5);
                repeat (len) char_plan.push_back($urandom_range(0, 3) == 0 ? CH_DOT
                                                 : CHAR_W'($urandom_range(CH_0, CH_9)));
            end else if (pick < 50) begin
                char_plan.push_back(CH_QUOTE);
                len = $urandom_range(0, 5);
                repeat (len) begin
                    c = CHAR_W'($urandom_range(1, CH_TOP));
                    char_plan.push_back(c == CH_QUOTE ? CH_LA : c);
                end
                // now and then the text ends inside the string
                char_plan.push_back($urandom_range(0, 11) == 0 ? CH_NUL : CH_QUOTE);
            end else if (pick < 62) begin
                char_plan.push_back(rand_symbol());
            end else if (pick < 72) begin
                len = $urandom_range(1, 3);
                repeat (len) char_plan.push_back(CHAR_W'($urandom_range(1, CH_SPACE)));
            end else if (pick < 78) begin
                char_plan.push_back(CH_SLASH);
                char_plan.push_back(CH_SLASH);
                len = $urandom_range(0, 4);
                repeat (len) begin
                    c = CHAR_W'($urandom_range(1, CH_TILDE));
                    char_plan.push_back(c == CH_LF ? CH_STAR : c);
                end
                char_plan.push_back($urandom_range(0, 9) == 0 ? CH_NUL : CH_LF);
            end else if (pick < 85) begin
                char_plan.push_back(CH_SLASH);
                char_plan.push_back(CH_STAR);
                len = $urandom_range(0, 5);
                repeat (len) begin
                    case ($urandom_range(0, 3))
                        0:       char_plan.push_back(CH_STAR);
                        1:       char_plan.push_back(CH_SLASH);
                        2:       char_plan.push_back(CH_LF);
                        default: char_plan.push_back(rand_letter());
                    endcase
                end
                if ($urandom_range(0, 9) == 0) begin
                    char_plan.push_back(CH_NUL);
                end else begin
                    char_plan.push_back(CH_STAR);
                    char_plan.push_back(CH_SLASH);
                end
            end else if (pick < 89) begin
                char_plan.push_back(CH_SLASH);
            end else if (pick < 92) begin
                char_plan.push_back(CH_NUL);
            end else begin
                char_plan.push_back(CHAR_W'($urandom_range(0, CH_TOP)));
            end
        end
    endtask

    // present one character, wait for the handshake, then predict
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic typed,
                             input t_res typed_res);
        int n0, gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - CHAR_W){1'b0}}, code};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n0 = token_items_due.size();
        scan_char(code);
        if (typed) begin
            // hand-written result stands in for the model's
            while (token_items_due.size() > n0) void'(token_items_due.pop_back());
            token_items_due.push_back(typed_res);
        end
        chars_sent++;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_plan();
        while (char_plan.size() > 0) send_char(char_plan.pop_front(), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver back-pressure
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
            if (receiver_idles) stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_res seen, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.ch       = o_m_tdata[20:0];
            seen.first    = o_m_tdata[21];
            seen.last     = o_m_tdata[22];
            seen.total    = o_m_tdata[38:23];
            seen.kind     = o_m_tuser[1:0];
            seen.eot      = o_m_tuser[2];
            seen.last_run = o_m_tlast;
            if (token_items_due.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: unexpected item ch=%h kind=%0d eot=%b", $realtime,
                             seen.ch, seen.kind, seen.eot);
                fail_count++;
            end else begin
                want = token_items_due.pop_front();
                items_checked++;
                if (seen.ch !== want.ch || seen.kind !== want.kind ||
                    seen.first !== want.first || seen.last !== want.last ||
                    seen.eot !== want.eot || seen.total !== want.total ||
                    seen.last_run !== want.last_run) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("%0t: mismatch on item %0d", $realtime, items_checked);
                        $display("  exp ch=%h kind=%0d first=%b last=%b eot=%b total=%0d tlast=%b",
                                 want.ch, want.kind, want.first, want.last, want.eot,
                                 want.total, want.last_run);
                        $display("  got ch=%h kind=%0d first=%b last=%b eot=%b total=%0d tlast=%b",
                                 seen.ch, seen.kind, seen.first, seen.last, seen.eot,
                                 seen.total, seen.last_run);
                    end
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        #(LIMIT_CYC * 2 * CLK_HALF);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int drain;
        scan_state  = SC_IDLE;
        held_ch     = '0;
        held_kind   = KIND_IDENT;
        held_first  = 1'b0;
        dot_seen    = 1'b0;
        tokens_seen = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk, both sides idling
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (int k = 0; k < N_DIR; k++)
            send_char(DIR_ROWS[k].code, DIR_ROWS[k].typed, DIR_ROWS[k].res);

        // random text: idling both sides, then none, then receiver-only stalls
        plan_text(260);
        send_plan();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        plan_text(220);
        char_plan.push_back(CH_NUL);
        send_plan();
        receiver_idles = 1'b1;
        plan_text(220);
        char_plan.push_back(CH_NUL);
        send_plan();

        // count must restart after end of text
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_char(CH_PLUS, 1'b0, '0);
        send_char(CH_NUL, 1'b0, '0);
        i_s_tvalid <= 1'b0;

        // drain, then wait for stray items
        while (token_items_due.size() > 0) @(posedge i_clk);
        drain = 8;
        repeat (drain) @(posedge i_clk);

        $display("Sent %0d characters over %0d texts; %0d token items checked.",
                 chars_sent, texts_closed, items_checked);
        $display("Mismatches or stray items: %0d", fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/source_text_tokenizer_top.sv
verif/tb_top.sv
